### rtl/ule_pkg.sv
// ----------------------------------------------------------------------------
// ule_pkg
// Shared types, codes and byte helpers of the UTF-8 line edit buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ule_pkg;

	localparam int BUF_DEPTH = 4096;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int LEN_W     = ADDR_W + 1;
	localparam int ACT_W     = 3;
	localparam int CNT_W     = 3;
	localparam int STAT_W    = 2;

	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	typedef enum logic [ACT_W-1:0] {
		ACT_TYPE    = 3'd0,
		ACT_NEWLINE = 3'd1,
		ACT_DELCHAR = 3'd2,
		ACT_DELWORD = 3'd3,
		ACT_CLEAR   = 3'd4,
		ACT_READ    = 3'd5
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_CTRL  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_CRD,
		S_CCHK,
		S_WPEEK,
		S_WTEST,
		S_RREQ,
		S_RDAT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return (c & CONT_MASK) == CONT_TAG;
	endfunction

endpackage

`default_nettype wire

### rtl/ule_store.sv
// ----------------------------------------------------------------------------
// ule_store
// Text byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ule_store (
	input  wire              clk,
	input  ule_pkg::mem_req_t req,
	output logic [7:0]       rdata
);
	import ule_pkg::*;

	logic [7:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/utf8_line_edit_buffer_top.sv
// ----------------------------------------------------------------------------
// utf8_line_edit_buffer_top
// Line edit buffer holding typed UTF-8 text; one edit or read per item.
// ----------------------------------------------------------------------------
// Appends write their bytes one at a time; character and word deletes step back
// through the store one byte at a time, reading each byte before removing it.
// One item at a time: the next item is taken the cycle after the previous result
// enters the output register; a result finding that register full holds the block.
// Reset clears the fill length and control state; store contents stay.
`timescale 1ns / 1ps
`default_nettype none

module utf8_line_edit_buffer_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [ule_pkg::ACT_W-1:0]    action,
	input  wire  [7:0]                   byte_0,
	input  wire  [7:0]                   byte_1,
	input  wire  [7:0]                   byte_2,
	input  wire  [7:0]                   byte_3,
	input  wire  [ule_pkg::CNT_W-1:0]    byte_count,
	input  wire  [ule_pkg::ADDR_W-1:0]   read_index,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [ule_pkg::STAT_W-1:0]   status,
	output logic [ule_pkg::LEN_W-1:0]    text_length,
	output logic [7:0]                   read_data
);
	import ule_pkg::*;

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  fill_q;
	logic              out_valid_q;
	logic              phase_q;
	action_t           action_q;
	logic [7:0]        byte_q [4];
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] index_q;
	status_t           status_q;
	logic [7:0]        data_q;
	logic [STAT_W-1:0] status_out_q;
	logic [LEN_W-1:0]  length_out_q;
	logic [7:0]        data_out_q;

	mem_req_t          mem_req;
	logic [7:0]        rdata;

	logic              accept;
	logic              slot_free;
	logic              finish;
	logic [CNT_W-1:0]  cnt_clamp;
	logic [CNT_W-1:0]  append_n;
	logic              is_ctrl;
	logic              is_full;
	logic [LEN_W:0]    fill_sum;
	logic [LEN_W-1:0]  fill_dec;
	logic              in_range;
	logic              rd_blank;
	logic              rd_nl;
	logic              rd_cont;

	ule_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign cnt_clamp = (byte_count > CNT_W'(4)) ? CNT_W'(4) : byte_count;
	assign append_n  = (action_t'(action) == ACT_NEWLINE) ? CNT_W'(1) : cnt_clamp;
	assign is_ctrl   = (cnt_clamp == CNT_W'(1)) &&
		(((byte_0 < CH_SPACE) && (byte_0 != CH_TAB)) || (byte_0 == CH_DEL));
	assign fill_sum  = {1'b0, fill_q} + (LEN_W + 1)'(append_n);
	assign is_full   = fill_sum > (LEN_W + 1)'(BUF_DEPTH);
	assign fill_dec  = fill_q - LEN_W'(1);
	assign in_range  = {1'b0, index_q} < fill_q;
	assign rd_blank  = is_blank(rdata);
	assign rd_nl     = rdata == CH_NL;
	assign rd_cont   = is_cont(rdata);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action_t'(action))
						ACT_TYPE: begin
							if (is_ctrl || is_full || cnt_clamp == '0) state_d = S_DONE;
							else state_d = S_WRITE;
						end
						ACT_NEWLINE: begin
							if (is_full) state_d = S_DONE;
							else state_d = S_WRITE;
						end
						ACT_DELCHAR: state_d = S_CRD;
						ACT_DELWORD: state_d = S_WPEEK;
						ACT_READ:    state_d = S_RREQ;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_WRITE: begin
				if (cnt_q == CNT_W'(1)) state_d = S_DONE;
			end
			S_CRD: begin
				if (fill_q != '0) state_d = S_CCHK;
				else if (action_q == ACT_DELWORD) state_d = S_WPEEK;
				else state_d = S_DONE;
			end
			S_CCHK: begin
				if (rd_cont) state_d = S_CRD;
				else if (action_q == ACT_DELWORD) state_d = S_WPEEK;
				else state_d = S_DONE;
			end
			S_WPEEK: begin
				if (fill_q == '0) state_d = S_DONE;
				else state_d = S_WTEST;
			end
			S_WTEST: begin
				if (rd_blank) state_d = phase_q ? S_DONE : S_WPEEK;
				else if (rd_nl) state_d = S_DONE;
				else if (rd_cont) state_d = S_CRD;
				else state_d = S_WPEEK;
			end
			S_RREQ: begin
				if (in_range) state_d = S_RDAT;
				else state_d = S_DONE;
			end
			S_RDAT: state_d = S_DONE;
			S_DONE: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = state_q == S_IDLE;
		finish        = (state_q == S_DONE) && slot_free;
		mem_req.we    = state_q == S_WRITE;
		mem_req.waddr = fill_q[ADDR_W-1:0];
		mem_req.wdata = byte_q[0];
		mem_req.re    = 1'b0;
		mem_req.raddr = fill_dec[ADDR_W-1:0];
		case (state_q)
			S_CRD:   mem_req.re = fill_q != '0;
			S_WPEEK: mem_req.re = fill_q != '0;
			S_RREQ: begin
				mem_req.re    = in_range;
				mem_req.raddr = index_q;
			end
			default: mem_req.re = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (accept) phase_q <= 1'b0;
			else if (state_q == S_WTEST && !rd_blank) phase_q <= 1'b1;
			if (accept && action_t'(action) == ACT_CLEAR) begin
				fill_q <= '0;
			end else if (state_q == S_WRITE) begin
				fill_q <= fill_q + LEN_W'(1);
			end else if (state_q == S_CCHK) begin
				fill_q <= fill_dec;
			end else if (state_q == S_WTEST &&
					(rd_blank ? !phase_q : !rd_nl)) begin
				fill_q <= fill_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q  <= action_t'(action);
			byte_q[0] <= (action_t'(action) == ACT_NEWLINE) ? CH_NL : byte_0;
			byte_q[1] <= byte_1;
			byte_q[2] <= byte_2;
			byte_q[3] <= byte_3;
			cnt_q     <= append_n;
			index_q   <= read_index;
			data_q    <= '0;
			if (action_t'(action) == ACT_TYPE && is_ctrl) status_q <= ST_CTRL;
			else if ((action_t'(action) == ACT_TYPE || action_t'(action) == ACT_NEWLINE)
					&& is_full) status_q <= ST_FULL;
			else status_q <= ST_DONE;
		end else begin
			if (state_q == S_WRITE) begin
				byte_q[0] <= byte_q[1];
				byte_q[1] <= byte_q[2];
				byte_q[2] <= byte_q[3];
				cnt_q     <= cnt_q - CNT_W'(1);
			end
			if (state_q == S_RREQ && !in_range) status_q <= ST_RANGE;
			if (state_q == S_RDAT) data_q <= rdata;
		end
		if (finish) begin
			status_out_q <= status_q;
			length_out_q <= fill_q;
			data_out_q   <= data_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_out_q;
	assign text_length = length_out_q;
	assign read_data   = data_out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(BUF_DEPTH))
		else $error("fill length beyond store depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> fill_q < LEN_W'(BUF_DEPTH))
		else $error("store write with no room");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> state_q == S_DONE)
		else $error("result finished over a waiting item");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action_t'(action) == ACT_CLEAR) |=> fill_q == '0)
		else $error("clear left bytes in store");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_RANGE) |-> read_data == 8'h00)
		else $error("out of range read returned data");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 line edit buffer top level.
// A scripted run of edge cases comes first: reads of an empty store, control
// bytes, odd byte counts, multibyte deletes and word deletes. Random typing
// sessions follow, with one pass that fills the store to the brim. Every
// result is compared with a local model of the text store, or with the row's
// given result. Both handshake sides idle at random, and the result side
// holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import ule_pkg::*;

	localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;
	localparam int EDIT_BUDGET  = 1800;
	localparam int WARMUP_EDITS = 350;
	localparam int STALL_AT     = 300;
	localparam int STALL_CYCLES = 600;
	localparam int SETTLE_CYCLES = 32;
	localparam longint RUN_LIMIT_NS = 64'd10_000_000;
	localparam int SCRIPT_LEN = 25;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [7:0]        b0;
		logic [7:0]        b1;
		logic [7:0]        b2;
		logic [7:0]        b3;
		logic [CNT_W-1:0]  count;
		logic [ADDR_W-1:0] index;
	} edit_t;

	typedef struct packed {
		status_t           status;
		logic [LEN_W-1:0]  length;
		logic [7:0]        data;
	} result_t;

	typedef struct packed {
		edit_t   edit;
		bit      given;
		result_t typed;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [ACT_W-1:0]    action;
	logic [7:0]          byte_0;
	logic [7:0]          byte_1;
	logic [7:0]          byte_2;
	logic [7:0]          byte_3;
	logic [CNT_W-1:0]    byte_count;
	logic [ADDR_W-1:0]   read_index;
	logic                out_valid;
	logic                out_ready;
	logic [STAT_W-1:0]   status;
	logic [LEN_W-1:0]    text_length;
	logic [7:0]          read_data;

	logic [7:0] text_mem [BUF_DEPTH];
	int         text_len;
	result_t    edit_results_due [$];

	int  edits_sent;
	int  results_checked;
	int  mismatches;
	int  full_rejects;
	int  ctrl_drops;
	int  range_reads;
	int  peak_fill;
	bit  send_calm;
	bit  recv_calm;

	script_row_t edit_script [SCRIPT_LEN] = '{
		'{'{ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_RANGE, 13'd0, 8'h00}},
		'{'{ACT_DELCHAR, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_DELWORD, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_CTRL, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'h1F, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_CTRL, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'h7F, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_CTRL, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'h09, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_DONE, 13'd1, 8'h00}},
		'{'{ACT_TYPE,    8'h41, 8'h00, 8'h00, 8'h00, 3'd0, 12'd0},    1'b1,
			'{ST_DONE, 13'd1, 8'h00}},
		'{'{ACT_TYPE,    8'h00, 8'h01, 8'h00, 8'h00, 3'd2, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'hF0, 8'h9F, 8'h98, 8'h80, 3'd7, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_NEWLINE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'hE2, 8'h82, 8'hAC, 8'h00, 3'd3, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd10},   1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_READ,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 12'hFFF},  1'b1,
			'{ST_RANGE, 13'd11, 8'h00}},
		'{'{ACT_SPARE6,  8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_DONE, 13'd11, 8'h00}},
		'{'{ACT_DELCHAR, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'h61, 8'h62, 8'h00, 8'h00, 3'd2, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'h20, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_DELWORD, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_DELWORD, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_CLEAR,   8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b1,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'h80, 8'hBF, 8'h00, 8'h00, 3'd2, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_DELCHAR, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_TYPE,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4, 12'd0},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}},
		'{'{ACT_READ,    8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 12'd3},    1'b0,
			'{ST_DONE, 13'd0, 8'h00}}
	};

	utf8_line_edit_buffer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.byte_0      (byte_0),
		.byte_1      (byte_1),
		.byte_2      (byte_2),
		.byte_3      (byte_3),
		.byte_count  (byte_count),
		.read_index  (read_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.text_length (text_length),
		.read_data   (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drop one codepoint from the tail of the text
	task automatic back_over_codepoint();
		int i;
		i = text_len;
		if (i == 0)
			return;
		while (i > 0 && (text_mem[i - 1] & CONT_MASK) == CONT_TAG)
			i--;
		if (i > 0)
			i--;
		text_len = i;
	endtask

	task automatic apply_edit(input edit_t e, output result_t r);
		logic [7:0] seq [4];
		int n;
		seq[0] = e.b0;
		seq[1] = e.b1;
		seq[2] = e.b2;
		seq[3] = e.b3;
		n = (e.count > 3'd4) ? 4 : int'(e.count);
		r.status = ST_DONE;
		r.data = 8'h00;
		case (e.action)
			ACT_TYPE: begin
				if (n == 1 && ((seq[0] < CH_SPACE && seq[0] != CH_TAB) || seq[0] == CH_DEL))
					r.status = ST_CTRL;
				else if (text_len + n > BUF_DEPTH)
					r.status = ST_FULL;
				else begin
					for (int k = 0; k < n; k++)
						text_mem[text_len + k] = seq[k];
					text_len += n;
				end
			end
			ACT_NEWLINE: begin
				if (text_len + 1 > BUF_DEPTH)
					r.status = ST_FULL;
				else begin
					text_mem[text_len] = CH_NL;
					text_len++;
				end
			end
			ACT_DELCHAR: back_over_codepoint();
			ACT_DELWORD: begin
				while (text_len > 0 && (text_mem[text_len - 1] == CH_SPACE ||
						text_mem[text_len - 1] == CH_TAB))
					back_over_codepoint();
				while (text_len > 0 && text_mem[text_len - 1] != CH_SPACE &&
						text_mem[text_len - 1] != CH_TAB && text_mem[text_len - 1] != CH_NL)
					back_over_codepoint();
			end
			ACT_CLEAR: text_len = 0;
			ACT_READ: begin
				if (int'(e.index) < text_len)
					r.data = text_mem[e.index];
				else
					r.status = ST_RANGE;
			end
			default: ;
		endcase
		r.length = LEN_W'(text_len);
		case (r.status)
			ST_FULL:  full_rejects++;
			ST_CTRL:  ctrl_drops++;
			ST_RANGE: range_reads++;
			default: ;
		endcase
		if (text_len > peak_fill)
			peak_fill = text_len;
	endtask

	function automatic edit_t four_byte_glyph();
		edit_t e;
		e.action = ACT_TYPE;
		e.b0 = 8'($urandom_range(8'hF0, 8'hF4));
		e.b1 = CONT_TAG | 8'($urandom_range(0, 63));
		e.b2 = CONT_TAG | 8'($urandom_range(0, 63));
		e.b3 = CONT_TAG | 8'($urandom_range(0, 63));
		e.count = 3'd4;
		e.index = ADDR_W'($urandom);
		return e;
	endfunction

	function automatic edit_t typed_glyph();
		edit_t e;
		int pick;
		e.action = ACT_TYPE;
		e.b0 = 8'($urandom);
		e.b1 = 8'($urandom);
		e.b2 = 8'($urandom);
		e.b3 = 8'($urandom);
		e.count = 3'd1;
		e.index = ADDR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35)
			e.b0 = 8'($urandom_range(8'h21, 8'h7E));
		else if (pick < 50)
			e.b0 = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
		else if (pick < 62) begin
			e.b0 = 8'($urandom_range(8'hC2, 8'hDF));
			e.b1 = CONT_TAG | 8'($urandom_range(0, 63));
			e.count = 3'd2;
		end else if (pick < 74) begin
			e.b0 = 8'($urandom_range(8'hE0, 8'hEF));
			e.b1 = CONT_TAG | 8'($urandom_range(0, 63));
			e.b2 = CONT_TAG | 8'($urandom_range(0, 63));
			e.count = 3'd3;
		end else if (pick < 86)
			e = four_byte_glyph();
		else if (pick < 92)
			e.b0 = ($urandom_range(0, 7) == 0) ? CH_DEL : 8'($urandom_range(0, 31));
		else
			e.count = CNT_W'($urandom_range(0, 7));
		return e;
	endfunction

	function automatic edit_t random_edit();
		edit_t e;
		int pick;
		e = typed_glyph();
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return e;
		else if (pick < 52)
			e.action = ACT_NEWLINE;
		else if (pick < 64)
			e.action = ACT_DELCHAR;
		else if (pick < 72)
			e.action = ACT_DELWORD;
		else if (pick < 74)
			e.action = ACT_CLEAR;
		else if (pick < 96) begin
			e.action = ACT_READ;
			if (text_len > 0 && $urandom_range(0, 3) != 0)
				e.index = ADDR_W'($urandom_range(0, text_len - 1));
		end else
			e.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
		return e;
	endfunction

	task automatic offer_edit(input edit_t e, input bit given, input result_t typed);
		int gap;
		result_t r;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= e.action;
		byte_0     <= e.b0;
		byte_1     <= e.b1;
		byte_2     <= e.b2;
		byte_3     <= e.b3;
		byte_count <= e.count;
		read_index <= e.index;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
		apply_edit(e, r);
		if (given)
			r = typed;
		edit_results_due.push_back(r);
		edits_sent++;
	endtask

	task automatic check_result();
		result_t due;
		results_checked++;
		if (edit_results_due.size() == 0) begin
			$error("result arrived with no edit outstanding");
			mismatches++;
		end else begin
			due = edit_results_due.pop_front();
			if (status !== due.status) begin
				$error("status: expected %0d, got %0d", due.status, status);
				mismatches++;
			end
			if (text_length !== due.length) begin
				$error("text_length: expected %0d, got %0d", due.length, text_length);
				mismatches++;
			end
			if (read_data !== due.data) begin
				$error("read_data: expected 0x%02h, got 0x%02h", due.data, read_data);
				mismatches++;
			end
		end
	endtask

	initial begin : result_sink
		int wait_cycles;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			// hold off long once so the block backs up into its input
			if (results_checked == STALL_AT)
				wait_cycles = STALL_CYCLES;
			else
				wait_cycles = recv_calm ? 0 : $urandom_range(0, 16);
			if (wait_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (out_valid !== 1'b1);
			check_result();
			@(posedge clk);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("utf8_line_edit_buffer_top verification failed");
		$finish;
	end

	initial begin : edit_source
		edit_t e;
		text_len = 0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_TYPE;
		byte_0     <= 8'h00;
		byte_1     <= 8'h00;
		byte_2     <= 8'h00;
		byte_3     <= 8'h00;
		byte_count <= '0;
		read_index <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (edit_script[i])
			offer_edit(edit_script[i].edit, edit_script[i].given, edit_script[i].typed);

		repeat (WARMUP_EDITS)
			offer_edit(random_edit(), 1'b0, '0);

		// fill the store to the last byte, mostly with four-byte codepoints
		e = random_edit();
		e.action = ACT_CLEAR;
		offer_edit(e, 1'b0, '0);
		while (text_len < BUF_DEPTH) begin
			if ($urandom_range(0, 9) == 0) begin
				e = typed_glyph();
				e.action = ACT_READ;
			end else if (text_len <= BUF_DEPTH - 4 && $urandom_range(0, 4) != 0)
				e = four_byte_glyph();
			else
				e = typed_glyph();
			offer_edit(e, 1'b0, '0);
		end
		e = four_byte_glyph();
		offer_edit(e, 1'b0, '0);
		e.action = ACT_NEWLINE;
		offer_edit(e, 1'b0, '0);
		e.action = ACT_READ;
		e.index = ADDR_W'(BUF_DEPTH - 1);
		offer_edit(e, 1'b0, '0);
		e.action = ACT_DELWORD;
		offer_edit(e, 1'b0, '0);
		e.action = ACT_DELCHAR;
		offer_edit(e, 1'b0, '0);

		while (edits_sent < EDIT_BUDGET)
			offer_edit(random_edit(), 1'b0, '0);
		in_valid <= 1'b0;

		while (edit_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d edits applied, %0d results compared, text peaked at %0d bytes",
			edits_sent, results_checked, peak_fill);
		$display("%0d appends refused on a full store, %0d control bytes dropped, %0d reads past the text",
			full_rejects, ctrl_drops, range_reads);
		if (mismatches == 0)
			$display("utf8_line_edit_buffer_top verification clean");
		else
			$display("utf8_line_edit_buffer_top verification failed");
		$finish;
	end

endmodule
